### hdl/tnm_pkg.sv
package tnm_pkg;

    localparam int NODE_W  = 10;
    localparam int CAP_W   = 16;
    localparam int TOTAL_W = 32;
    localparam int FLOW_W  = 16;
    localparam int BCOST_W = 8;
    // Working width of path costs during the climb and the cache refresh.
    localparam int CW      = 16;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [BCOST_W-1:0] COST_INF = 8'hFF;
    localparam logic [FLOW_W-1:0]  FLOW_MAX = 16'h7FFF;
    localparam logic [FLOW_W-1:0]  FLOW_MIN = 16'h8000;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIMB_RD,
        ST_CLIMB_EV,
        ST_DECIDE,
        ST_PATH_RD,
        ST_PATH_WR,
        ST_PATH_NEXT,
        ST_SLOT_RD,
        ST_SLOT_WR,
        ST_SLOT_DONE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_UP_REF,
        ST_UP_NEXT,
        ST_REF_K,
        ST_REF_L,
        ST_REF_R,
        ST_REF_W,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RET_PATH,
        RET_SLOT,
        RET_UP
    } ret_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_cost;
        logic [NODE_W-1:0]  matched_node;
        logic               no_match;
    } res_t;

    function automatic state_t ret_state(input ret_t r);
        state_t s;
        case (r)
            RET_PATH: s = ST_PATH_NEXT;
            RET_SLOT: s = ST_SLOT_DONE;
            RET_UP:   s = ST_UP_NEXT;
            default:  s = ST_UP_NEXT;
        endcase
        return s;
    endfunction

endpackage

### hdl/tnm_req_if.sv
interface tnm_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [tnm_pkg::NODE_W-1:0]   node;
    logic [tnm_pkg::CAP_W-1:0]    capacity_value;

    modport source (output valid, operation, node, capacity_value, input ready);
    modport sink (input valid, operation, node, capacity_value, output ready);
endinterface

### hdl/tnm_res_if.sv
interface tnm_res_if;
    logic                         valid;
    logic                         ready;
    logic [tnm_pkg::TOTAL_W-1:0]  total_cost;
    logic [tnm_pkg::NODE_W-1:0]   matched_node;
    logic                         no_match;

    modport source (output valid, total_cost, matched_node, no_match, input ready);
    modport sink (input valid, total_cost, matched_node, no_match, output ready);
endinterface

### hdl/tnm_node_ram.sv
// Node store: one write port and one read port with registered read data.
module tnm_node_ram #(
    parameter int AW = 10,
    parameter int DW = 50
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

### hdl/tnm_cost_unit.sv
// Shared add and compare: candidate cost and whether it replaces the current best.
module tnm_cost_unit (
    input  logic [tnm_pkg::BCOST_W-1:0]  cost,
    input  logic signed [tnm_pkg::CW-1:0] off,
    input  logic signed [tnm_pkg::CW-1:0] best,
    input  logic                          have,
    output logic signed [tnm_pkg::CW-1:0] cand,
    output logic                          take
);

    logic signed [tnm_pkg::CW-1:0] cost_ext;

    assign cost_ext = {{(tnm_pkg::CW - tnm_pkg::BCOST_W){cost[tnm_pkg::BCOST_W-1]}}, cost};
    assign cand     = cost_ext + off;
    assign take     = !have || (cand < best);

endmodule

### hdl/tnm_seq.sv
// Sequencer for climb, flow updates and cache refreshes over the node store.
module tnm_seq #(
    parameter int NODES = 1023,
    parameter int NW    = 10,
    parameter int WW    = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [tnm_pkg::NODE_W-1:0]    in_node,
    input  logic [tnm_pkg::CAP_W-1:0]     in_cap,
    output logic                          res_valid,
    input  logic                          res_ready,
    output tnm_pkg::res_t                 res,
    output logic                          mem_we,
    output logic [NW-1:0]                 mem_waddr,
    output logic [WW-1:0]                 mem_wdata,
    output logic [NW-1:0]                 mem_raddr,
    input  logic [WW-1:0]                 mem_rdata
);

    typedef struct packed {
        logic [tnm_pkg::CAP_W-1:0]   slot;
        logic [tnm_pkg::FLOW_W-1:0]  flow;
        logic [tnm_pkg::BCOST_W-1:0] cost;
        logic [NW-1:0]               best;
    } word_t;

    localparam int CW = tnm_pkg::CW;

    tnm_pkg::state_t state_reg, state_next;
    tnm_pkg::ret_t   ret_reg, ret_next;
    logic [NW-1:0]   cur_reg, cur_next;
    logic [NW-1:0]   p_reg, p_next;
    logic [NW-1:0]   v_reg, v_next;
    logic [NW-1:0]   y_reg, y_next;
    logic [NW-1:0]   rk_reg, rk_next;
    logic [NW-1:0]   rwho_reg, rwho_next;
    logic [NW-1:0]   clr_reg, clr_next;
    logic            dir_reg, dir_next;
    logic            op_reg, op_next;
    logic            found_reg, found_next;
    logic signed [CW-1:0] bestc_reg, bestc_next;
    logic signed [CW-1:0] t_reg, t_next;
    logic signed [CW-1:0] rbest_reg, rbest_next;
    word_t           wk_reg, wk_next;
    logic [tnm_pkg::CAP_W-1:0]   cap_reg, cap_next;
    logic [tnm_pkg::TOTAL_W-1:0] total_reg, total_next;
    tnm_pkg::res_t   res_reg, res_next;

    word_t           rd_word, wr_word;
    logic [NW:0]     ch_l, ch_r;
    logic            lv, rv, rk_ok, in_range;
    logic [NW-1:0]   cur_up;
    logic [tnm_pkg::FLOW_W-1:0] flow_adj;

    logic [tnm_pkg::BCOST_W-1:0] u_cost;
    logic signed [CW-1:0] u_off, u_best, u_cand;
    logic            u_have, u_take;

    tnm_cost_unit u_cost_unit (
        .cost (u_cost),
        .off  (u_off),
        .best (u_best),
        .have (u_have),
        .cand (u_cand),
        .take (u_take)
    );

    assign rd_word   = mem_rdata;
    assign mem_wdata = wr_word;
    assign ch_l      = {rk_reg, 1'b0};
    assign ch_r      = {rk_reg, 1'b1};
    assign lv        = (ch_l <= NODES);
    assign rv        = (ch_r <= NODES);
    assign rk_ok     = (rk_reg != '0) && (rk_reg <= NODES);
    assign cur_up    = cur_reg >> 1;
    assign in_range  = (in_node != '0) && (32'(in_node) <= NODES);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnm_pkg::ST_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg   <= ret_next;
        cur_reg   <= cur_next;
        p_reg     <= p_next;
        v_reg     <= v_next;
        y_reg     <= y_next;
        rk_reg    <= rk_next;
        rwho_reg  <= rwho_next;
        dir_reg   <= dir_next;
        op_reg    <= op_next;
        found_reg <= found_next;
        bestc_reg <= bestc_next;
        t_reg     <= t_next;
        rbest_reg <= rbest_next;
        wk_reg    <= wk_next;
        cap_reg   <= cap_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cur_next   = cur_reg;
        p_next     = p_reg;
        v_next     = v_reg;
        y_next     = y_reg;
        rk_next    = rk_reg;
        rwho_next  = rwho_reg;
        clr_next   = clr_reg;
        dir_next   = dir_reg;
        op_next    = op_reg;
        found_next = found_reg;
        bestc_next = bestc_reg;
        t_next     = t_reg;
        rbest_next = rbest_reg;
        wk_next    = wk_reg;
        cap_next   = cap_reg;
        total_next = total_reg;
        res_next   = res_reg;

        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cur_reg;
        mem_raddr  = cur_reg;
        wr_word    = rd_word;

        // Default unit use is the cache refresh against a child entry.
        u_cost = rd_word.cost;
        u_off  = rd_word.flow[tnm_pkg::FLOW_W-1] ? -CW'(1) : CW'(1);
        u_best = rbest_reg;
        u_have = (rwho_reg != '0);

        flow_adj = rd_word.flow;
        if (dir_reg)
        begin
            if (rd_word.flow != tnm_pkg::FLOW_MAX)
            begin
                flow_adj = rd_word.flow + 16'd1;
            end
        end
        else
        begin
            if (rd_word.flow != tnm_pkg::FLOW_MIN)
            begin
                flow_adj = rd_word.flow - 16'd1;
            end
        end

        case (state_reg)
            tnm_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                wr_word   = '{slot: '0, flow: '0, cost: tnm_pkg::COST_INF, best: '0};
                if (clr_reg == NW'(NODES))
                begin
                    state_next = tnm_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            tnm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_op;
                    p_next     = NW'(in_node);
                    cap_next   = in_cap;
                    found_next = 1'b0;
                    t_next     = '0;
                    bestc_next = '0;
                    if (in_op == tnm_pkg::OP_LOAD)
                    begin
                        if (in_range)
                        begin
                            state_next = tnm_pkg::ST_LOAD_RD;
                        end
                        else
                        begin
                            res_next   = '{total_cost: total_reg, matched_node: '0,
                                           no_match: 1'b0};
                            state_next = tnm_pkg::ST_OUT;
                        end
                    end
                    else if (in_range)
                    begin
                        state_next = tnm_pkg::ST_CLIMB_RD;
                    end
                    else
                    begin
                        state_next = tnm_pkg::ST_DECIDE;
                    end
                end
            end
            tnm_pkg::ST_CLIMB_RD:
            begin
                mem_raddr  = p_reg;
                cur_next   = p_reg;
                state_next = tnm_pkg::ST_CLIMB_EV;
            end
            tnm_pkg::ST_CLIMB_EV:
            begin
                u_cost = rd_word.cost;
                u_off  = t_reg;
                u_best = bestc_reg;
                u_have = found_reg;
                if ((rd_word.best != '0) && u_take)
                begin
                    found_next = 1'b1;
                    bestc_next = u_cand;
                    y_next     = rd_word.best;
                    v_next     = cur_reg;
                end
                if (!rd_word.flow[tnm_pkg::FLOW_W-1] && (rd_word.flow != '0))
                begin
                    t_next = t_reg - CW'(1);
                end
                else
                begin
                    t_next = t_reg + CW'(1);
                end
                if (cur_up != '0)
                begin
                    mem_raddr = cur_up;
                    cur_next  = cur_up;
                end
                else
                begin
                    state_next = tnm_pkg::ST_DECIDE;
                end
            end
            tnm_pkg::ST_DECIDE:
            begin
                if (!found_reg || (y_reg == '0) || (y_reg > NODES))
                begin
                    res_next   = '{total_cost: total_reg, matched_node: '0, no_match: 1'b1};
                    state_next = tnm_pkg::ST_OUT;
                end
                else
                begin
                    cur_next   = p_reg;
                    dir_next   = 1'b0;
                    state_next = tnm_pkg::ST_PATH_RD;
                end
            end
            tnm_pkg::ST_PATH_RD:
            begin
                if ((cur_reg == v_reg) || (cur_reg == '0))
                begin
                    if (!dir_reg)
                    begin
                        state_next = tnm_pkg::ST_SLOT_RD;
                    end
                    else
                    begin
                        cur_next   = v_reg;
                        state_next = tnm_pkg::ST_UP_REF;
                    end
                end
                else
                begin
                    mem_raddr  = cur_reg;
                    state_next = tnm_pkg::ST_PATH_WR;
                end
            end
            tnm_pkg::ST_PATH_WR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = cur_reg;
                wr_word      = rd_word;
                wr_word.flow = flow_adj;
                rk_next      = cur_up;
                ret_next     = tnm_pkg::RET_PATH;
                state_next   = tnm_pkg::ST_REF_K;
            end
            tnm_pkg::ST_PATH_NEXT:
            begin
                cur_next   = cur_up;
                state_next = tnm_pkg::ST_PATH_RD;
            end
            tnm_pkg::ST_SLOT_RD:
            begin
                mem_raddr  = y_reg;
                state_next = tnm_pkg::ST_SLOT_WR;
            end
            tnm_pkg::ST_SLOT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = y_reg;
                wr_word   = rd_word;
                if (rd_word.slot != '0)
                begin
                    wr_word.slot = rd_word.slot - 16'd1;
                end
                rk_next    = y_reg;
                ret_next   = tnm_pkg::RET_SLOT;
                state_next = tnm_pkg::ST_REF_K;
            end
            tnm_pkg::ST_SLOT_DONE:
            begin
                cur_next   = y_reg;
                dir_next   = 1'b1;
                state_next = tnm_pkg::ST_PATH_RD;
            end
            tnm_pkg::ST_LOAD_RD:
            begin
                mem_raddr  = p_reg;
                cur_next   = p_reg;
                state_next = tnm_pkg::ST_LOAD_WR;
            end
            tnm_pkg::ST_LOAD_WR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = p_reg;
                wr_word      = rd_word;
                wr_word.slot = cap_reg;
                state_next   = tnm_pkg::ST_UP_REF;
            end
            tnm_pkg::ST_UP_REF:
            begin
                rk_next    = cur_reg;
                ret_next   = tnm_pkg::RET_UP;
                state_next = tnm_pkg::ST_REF_K;
            end
            tnm_pkg::ST_UP_NEXT:
            begin
                if (cur_up == '0)
                begin
                    state_next = tnm_pkg::ST_FINISH;
                end
                else
                begin
                    cur_next   = cur_up;
                    state_next = tnm_pkg::ST_UP_REF;
                end
            end
            tnm_pkg::ST_REF_K:
            begin
                mem_raddr = rk_reg;
                if (rk_ok)
                begin
                    state_next = tnm_pkg::ST_REF_L;
                end
                else
                begin
                    state_next = tnm_pkg::ret_state(ret_reg);
                end
            end
            tnm_pkg::ST_REF_L:
            begin
                wk_next    = rd_word;
                rbest_next = '0;
                rwho_next  = (rd_word.slot != '0) ? rk_reg : '0;
                mem_raddr  = ch_l[NW-1:0];
                state_next = tnm_pkg::ST_REF_R;
            end
            tnm_pkg::ST_REF_R:
            begin
                if (lv && (rd_word.best != '0) && u_take)
                begin
                    rbest_next = u_cand;
                    rwho_next  = rd_word.best;
                end
                mem_raddr  = ch_r[NW-1:0];
                state_next = tnm_pkg::ST_REF_W;
            end
            tnm_pkg::ST_REF_W:
            begin
                wr_word = '{slot: wk_reg.slot, flow: wk_reg.flow,
                            cost: rbest_reg[tnm_pkg::BCOST_W-1:0], best: rwho_reg};
                if (rv && (rd_word.best != '0) && u_take)
                begin
                    wr_word.cost = u_cand[tnm_pkg::BCOST_W-1:0];
                    wr_word.best = rd_word.best;
                end
                if (wr_word.best == '0)
                begin
                    wr_word.cost = tnm_pkg::COST_INF;
                end
                mem_we     = 1'b1;
                mem_waddr  = rk_reg;
                state_next = tnm_pkg::ret_state(ret_reg);
            end
            tnm_pkg::ST_FINISH:
            begin
                if (op_reg == tnm_pkg::OP_REQUEST)
                begin
                    total_next = total_reg +
                                 {{(tnm_pkg::TOTAL_W - CW){bestc_reg[CW-1]}}, bestc_reg};
                    res_next   = '{total_cost: total_next,
                                   matched_node: tnm_pkg::NODE_W'(y_reg), no_match: 1'b0};
                end
                else
                begin
                    res_next = '{total_cost: total_reg, matched_node: '0, no_match: 1'b0};
                end
                state_next = tnm_pkg::ST_OUT;
            end
            tnm_pkg::ST_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = tnm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tnm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/tree_nearest_slot_min_cost_matcher_top.sv
// A load writes the slot count of its node, then refreshes the cached best of each node
// from there up to the root. A request climbs from its node to the root, then updates
// the flow of each edge on both paths to the meeting ancestor, takes the slot and
// refreshes each level from the meeting ancestor to the root. One request at a time;
// a new one is taken only in the idle state. Reset: rst_n is asynchronous, active low;
// afterwards every store entry up to NODES is cleared, with no request accepted, before the block is ready.
module tree_nearest_slot_min_cost_matcher_top #(
    parameter int NODES = 1023
) (
    input  logic          clk,
    input  logic          rst_n,
    tnm_req_if.sink       req_ch,
    tnm_res_if.source     res_ch
);

    // Node index width and the width of one node-store word: free slots, edge
    // flow to the parent, cached best cost and cached best node.
    localparam int NW = $clog2(NODES + 1);
    localparam int WW = tnm_pkg::CAP_W + tnm_pkg::FLOW_W + tnm_pkg::BCOST_W + NW;

    logic            mem_we;
    logic [NW-1:0]   mem_waddr;
    logic [WW-1:0]   mem_wdata;
    logic [NW-1:0]   mem_raddr;
    logic [WW-1:0]   mem_rdata;

    logic            seq_res_valid;
    logic            seq_res_ready;
    tnm_pkg::res_t   seq_res;

    logic            out_valid_reg;
    tnm_pkg::res_t   out_data_reg;

    // All per-node state sits in one memory; the sequencer walks it one read a
    // cycle and writes back whole words.
    tnm_node_ram #(
        .AW (NW),
        .DW (WW)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The sequencer runs the climb to the root, both flow paths and every cache
    // refresh through one shared add-and-compare unit.
    tnm_seq #(
        .NODES (NODES),
        .NW    (NW),
        .WW    (WW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_ch.valid),
        .in_ready  (req_ch.ready),
        .in_op     (req_ch.operation),
        .in_node   (req_ch.node),
        .in_cap    (req_ch.capacity_value),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // The output register lets the sequencer go back for the next request while
    // the previous result still waits to be taken.
    assign seq_res_ready = !out_valid_reg || res_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_res_valid && seq_res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res_valid && seq_res_ready)
        begin
            out_data_reg <= seq_res;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.total_cost   = out_data_reg.total_cost;
    assign res_ch.matched_node = out_data_reg.matched_node;
    assign res_ch.no_match     = out_data_reg.no_match;

endmodule

### hdl/tnm_checker.sv
module tnm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [tnm_pkg::TOTAL_W-1:0] total_cost,
    input logic [tnm_pkg::NODE_W-1:0]  matched_node,
    input logic                        no_match
);

    // The block leaves its idle state when it accepts a request, so it is busy right after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("block ready in the cycle after a request was accepted");

    a_no_match_node: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && no_match |-> matched_node == '0)
        else $error("failed request reports a matched node");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(total_cost)
            && $stable(matched_node) && $stable(no_match))
        else $error("stalled result changed");

endmodule

bind tree_nearest_slot_min_cost_matcher_top tnm_checker u_tnm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_ch.valid),
    .req_ready    (req_ch.ready),
    .res_valid    (res_ch.valid),
    .res_ready    (res_ch.ready),
    .total_cost   (res_ch.total_cost),
    .matched_node (res_ch.matched_node),
    .no_match     (res_ch.no_match)
);

### verif/tb_tree_nearest_slot_min_cost_matcher_top.sv
`timescale 1ns / 100ps

module tb_tree_nearest_slot_min_cost_matcher_top;

    localparam int NODE_COUNT = 1023;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    tnm_req_if req_ch ();
    tnm_res_if res_ch ();

    tree_nearest_slot_min_cost_matcher_top #(.NODES(NODE_COUNT)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch.sink),
        .res_ch (res_ch.source)
    );

    // The clock runs at a 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // This is a mirror of the tree state, kept by the testbench's own matcher model.
    logic [tnm_pkg::CAP_W-1:0]   slots_left [0:NODE_COUNT];
    logic [tnm_pkg::FLOW_W-1:0]  flow_up [0:NODE_COUNT];
    logic [tnm_pkg::BCOST_W-1:0] cache_cost [0:NODE_COUNT];
    logic [tnm_pkg::NODE_W-1:0]  cache_node [0:NODE_COUNT];
    logic [tnm_pkg::TOTAL_W-1:0] running_total;

    tnm_pkg::res_t pending_results[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  errors;
    int  requests_sent;
    int  results_seen;
    int  matches_seen;
    int  misses_seen;
    int  quiet_cycles;

    function automatic int flow_val(input int k);
        return $signed(flow_up[k]);
    endfunction

    // This rebuilds the cached cheapest slot of one subtree from its own slots and its children.
    function automatic void refresh_cache(input int k);
        int best;
        int who;
        int ch;
        int cand;
        best = 0;
        who = 0;
        if (k == 0 || k > NODE_COUNT)
            return;
        if (slots_left[k] != 0)
            who = k;
        for (int i = 0; i < 2; i++)
        begin
            ch = 2 * k + i;
            if (ch <= NODE_COUNT && cache_node[ch] != 0)
            begin
                cand = $signed(cache_cost[ch]) + (flow_val(ch) < 0 ? -1 : 1);
                if (who == 0 || cand < best)
                begin
                    best = cand;
                    who = cache_node[ch];
                end
            end
        end
        cache_node[k] = who;
        cache_cost[k] = (who != 0) ? best[tnm_pkg::BCOST_W-1:0] : tnm_pkg::COST_INF;
    endfunction

    function automatic void bump_flow(input int k, input int d);
        int v;
        v = flow_val(k) + d;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        flow_up[k] = v[tnm_pkg::FLOW_W-1:0];
    endfunction

    // This returns the expected result of one request and updates the mirror of the tree.
    function automatic tnm_pkg::res_t match_request(input logic op, input int p,
                                                    input int cap);
        tnm_pkg::res_t r;
        int   climb_cost;
        int   best_cost;
        int   meet;
        int   winner;
        int   c;
        bit   found;
        bit   in_range;
        climb_cost = 0;
        best_cost = 0;
        meet = 0;
        winner = 0;
        found = 1'b0;
        in_range = (p >= 1 && p <= NODE_COUNT);
        r.matched_node = '0;
        r.no_match = 1'b0;
        if (op == tnm_pkg::OP_LOAD)
        begin
            if (in_range)
            begin
                slots_left[p] = cap[tnm_pkg::CAP_W-1:0];
                for (int u = p; u != 0; u = u >> 1)
                    refresh_cache(u);
            end
            r.total_cost = running_total;
            return r;
        end
        if (in_range)
        begin
            for (int u = p; u != 0; u = u >> 1)
            begin
                if (cache_node[u] != 0)
                begin
                    c = $signed(cache_cost[u]) + climb_cost;
                    if (!found || c < best_cost)
                    begin
                        found = 1'b1;
                        best_cost = c;
                        winner = cache_node[u];
                        meet = u;
                    end
                end
                climb_cost += (flow_val(u) > 0) ? -1 : 1;
            end
        end
        if (!found || winner == 0 || winner > NODE_COUNT)
        begin
            r.total_cost = running_total;
            r.no_match = 1'b1;
            return r;
        end
        r.matched_node = winner[tnm_pkg::NODE_W-1:0];
        for (int u = p; u != meet && u != 0; u = u >> 1)
        begin
            bump_flow(u, -1);
            refresh_cache(u >> 1);
        end
        if (slots_left[winner] != 0)
            slots_left[winner] = slots_left[winner] - 1'b1;
        refresh_cache(winner);
        for (int u = winner; u != meet && u != 0; u = u >> 1)
        begin
            bump_flow(u, 1);
            refresh_cache(u >> 1);
        end
        for (int u = meet; u != 0; u = u >> 1)
            refresh_cache(u);
        running_total = running_total + best_cost;
        r.total_cost = running_total;
        return r;
    endfunction

    // This offers one request, with random idle cycles first, and waits for acceptance.
    // The valid line stays high after acceptance; idle cycles and the drain lower it.
    task automatic send_request(input logic op, input int p, input int cap);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.node <= p[tnm_pkg::NODE_W-1:0];
        req_ch.capacity_value <= cap[tnm_pkg::CAP_W-1:0];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(match_request(op, p, cap));
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // The receiver stalls at random, or holds off completely while hold_off is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted result is checked against the oldest expected result.
    always @(posedge clk)
    begin
        tnm_pkg::res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: total %0d node %0d", res_ch.total_cost,
                       res_ch.matched_node);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.no_match)
                    misses_seen++;
                else if (want.matched_node != 0)
                    matches_seen++;
                if (res_ch.total_cost !== want.total_cost)
                begin
                    $error("total_cost expected %0d actual %0d", want.total_cost,
                           res_ch.total_cost);
                    errors++;
                end
                if (res_ch.matched_node !== want.matched_node)
                begin
                    $error("matched_node expected %0d actual %0d", want.matched_node,
                           res_ch.matched_node);
                    errors++;
                end
                if (res_ch.no_match !== want.no_match)
                begin
                    $error("no_match expected %0d actual %0d", want.no_match,
                           res_ch.no_match);
                    errors++;
                end
            end
        end
    end

    // The watchdog ends the run after a long stretch in which no handshake completes.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Node indexes are mostly kept shallow so that the tree stays small and busy.
    function automatic int pick_node();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $urandom_range(1, 15);
        if (sel < 85)
            return $urandom_range(1, 127);
        if (sel < 97)
            return $urandom_range(1, NODE_COUNT);
        return 0;
    endfunction

    // The directed part covers the field extremes, empty-tree misses, ties and out-of-range nodes.
    task automatic test_directed();
        send_request(tnm_pkg::OP_REQUEST, 1, 0);
        send_request(tnm_pkg::OP_REQUEST, NODE_COUNT, 16'hFFFF);
        send_request(tnm_pkg::OP_LOAD, 0, 16'hFFFF);
        send_request(tnm_pkg::OP_REQUEST, 0, 0);
        send_request(tnm_pkg::OP_LOAD, NODE_COUNT, 1);
        send_request(tnm_pkg::OP_REQUEST, 1, 0);
        send_request(tnm_pkg::OP_REQUEST, 1, 0);
        send_request(tnm_pkg::OP_LOAD, 2, 1);
        send_request(tnm_pkg::OP_LOAD, 3, 1);
        send_request(tnm_pkg::OP_REQUEST, 1, 0);
        send_request(tnm_pkg::OP_REQUEST, 1, 0);
        send_request(tnm_pkg::OP_LOAD, 4, 2);
        send_request(tnm_pkg::OP_REQUEST, 5, 0);
        send_request(tnm_pkg::OP_REQUEST, 5, 0);
        send_request(tnm_pkg::OP_LOAD, 682, 16'hFFFF);
        send_request(tnm_pkg::OP_REQUEST, 341, 16'h5555);
        send_request(tnm_pkg::OP_REQUEST, 1023, 16'hAAAA);
        send_request(tnm_pkg::OP_LOAD, 682, 0);
        send_request(tnm_pkg::OP_LOAD, 1, 3);
        send_request(tnm_pkg::OP_REQUEST, 512, 0);
        send_request(tnm_pkg::OP_REQUEST, 1, 0);
        wait_drained();
    endtask

    // The random part mixes loads and requests, with requests more common than loads.
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 35)
                send_request(tnm_pkg::OP_LOAD, pick_node(),
                             ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF)
                                                      : $urandom_range(3));
            else
                send_request(tnm_pkg::OP_REQUEST, pick_node(), $urandom_range(16'hFFFF));
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while requests keep arriving, so the block backs up.
    task automatic test_backpressure();
        int held;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                held = 0;
                while (held < 1500)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                send_request(i % 3 == 0 ? tnm_pkg::OP_LOAD : tnm_pkg::OP_REQUEST,
                             $urandom_range(1, 31), $urandom_range(2));
        join
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        matches_seen = 0;
        misses_seen = 0;
        quiet_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        running_total = '0;
        for (int k = 0; k <= NODE_COUNT; k++)
        begin
            slots_left[k] = '0;
            flow_up[k] = '0;
            cache_cost[k] = tnm_pkg::COST_INF;
            cache_node[k] = '0;
        end
        req_ch.valid = 1'b0;
        req_ch.operation = tnm_pkg::OP_LOAD;
        req_ch.node = '0;
        req_ch.capacity_value = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(300, 0, 0);
        test_random(250, 69, 0);
        test_random(250, 0, 69);
        test_random(250, 15, 15);
        test_backpressure();
        test_random(100, 0, 0);

        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("Sent %0d requests; %0d results checked, %0d matches and %0d misses.",
                 requests_sent, results_seen, matches_seen, misses_seen);
        $display("Idle and stall phases, a long receiver hold-off and out-of-range nodes ran.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hdl/tnm_pkg.sv
hdl/tnm_req_if.sv
hdl/tnm_res_if.sv
hdl/tnm_node_ram.sv
hdl/tnm_cost_unit.sv
hdl/tnm_seq.sv
hdl/tree_nearest_slot_min_cost_matcher_top.sv
hdl/tnm_checker.sv
verif/tb_tree_nearest_slot_min_cost_matcher_top.sv
